### design/crt_pkg.sv
package crt_pkg;

  localparam int MAX_CHUNKS = 4096;

  // received map is held as words of WORD_W chunk bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int WORDS  = (MAX_CHUNKS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int REM_W  = (CNT_W > BIT_W + 1) ? CNT_W : BIT_W + 1;

  localparam int COUNT_W = 13;
  localparam int NUMBER_W = 16;
  localparam int MISS_W  = 12;
  localparam int IDLE_W  = 16;

  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd5000;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_CHUNK = 2'd2,
    ACT_TICK  = 2'd3
  } crt_act_e;

  typedef enum logic {
    REPLY_STATUS = 1'b0,
    REPLY_RETX   = 1'b1
  } crt_reply_e;

  typedef enum logic [1:0] {
    STAT_STOPPED  = 2'd0,
    STAT_STARTED  = 2'd1,
    STAT_COMPLETE = 2'd2
  } crt_status_e;

  typedef struct packed {
    crt_act_e              action;
    logic [COUNT_W-1:0]    chunk_count;
    logic [NUMBER_W-1:0]   chunk_number;
  } crt_req_t;

  typedef struct packed {
    crt_reply_e            reply_kind;
    crt_status_e           report_code;
    logic [MISS_W-1:0]     missing_index;
  } crt_rsp_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     addr;
    logic [WORD_W-1:0]     data;
  } crt_ram_wr_t;

endpackage

### design/chunk_receipt_tracker.sv
// Start and stop results pass the pending register, then the output register;
// start then clears the received map, one word per cycle (WORDS = 128 words at
// 4096 chunks). A chunk reads its map word, then marks it and writes it back.
// A tick that times out scans the map one word per cycle until a miss or the
// last word. Requests are taken one at a time, in the ready state with no result
// pending. After reset the map is cleared the same way before the first request.
module chunk_receipt_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  crt_pkg::crt_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output crt_pkg::crt_rsp_t              out_rsp_o,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [crt_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [crt_pkg::CFG_DATA_W-1:0] pwdata_i,
  output logic [crt_pkg::CFG_DATA_W-1:0] prdata_o,
  output logic                           pready_o
);
  import crt_pkg::*;

  logic [IDLE_W-1:0] timeout;
  crt_ram_wr_t       ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  crt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .timeout_o (timeout)
  );

  crt_ram #(
    .Width (WORD_W),
    .Depth (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .timeout_i   (timeout),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

### design/crt_ram.sv
module crt_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/crt_cfg.sv
module crt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [crt_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [crt_pkg::CFG_DATA_W-1:0] pwdata_i,
  output logic [crt_pkg::CFG_DATA_W-1:0] prdata_o,
  output logic                           pready_o,
  output logic [crt_pkg::IDLE_W-1:0]     timeout_o
);
  import crt_pkg::*;

  logic [IDLE_W-1:0] timeout_q, timeout_d;
  logic              wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en && paddr_i[2] == REG_TIMEOUT) begin
      timeout_d = pwdata_i[IDLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata_o  = (paddr_i[2] == REG_TIMEOUT) ? CFG_DATA_W'(timeout_q) : '0;
  assign timeout_o = timeout_q;

endmodule

### design/crt_core.sv
module crt_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  crt_pkg::crt_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output crt_pkg::crt_rsp_t            out_rsp_o,
  input  logic [crt_pkg::IDLE_W-1:0]   timeout_i,
  output crt_pkg::crt_ram_wr_t         ram_wr_o,
  output logic [crt_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [crt_pkg::WORD_W-1:0]   ram_rdata_i
);
  import crt_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READY,
    S_MARK,
    S_SCAN
  } state_e;

  typedef enum logic [1:0] {
    M_IDLE,
    M_RECV,
    M_DONE
  } mode_e;

  state_e            st_q, st_d;
  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  expected_q, expected_d;
  logic [CNT_W-1:0]  received_q, received_d;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BIT_W-1:0]  bitpos_q, bitpos_d;
  logic              pend_q, pend_d;
  crt_rsp_t          pend_res_q, pend_res_d;
  logic              out_valid_q, out_valid_d;
  crt_rsp_t          out_q, out_d;

  logic              accept;
  logic [IDLE_W-1:0] idle_inc;
  logic [31:0]       count_ext;
  logic [WORD_W-1:0] bit_oh;
  logic              already;
  logic [CNT_W-1:0]  cnt_new;
  logic [REM_W-1:0]  base;
  logic [REM_W-1:0]  rem;
  logic              last_word;
  logic [WORD_W-1:0] valid_mask;
  logic [WORD_W-1:0] miss;
  logic [WORD_W-1:0] low_oh;
  logic [BIT_W-1:0]  low_pos;
  logic [ADDR_W+BIT_W-1:0] miss_idx;

  assign in_ready_o = (st_q == S_READY) && !pend_q;
  assign accept     = in_valid_i && in_ready_o;

  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign count_ext = 32'(in_req_i.chunk_count);

  assign bit_oh  = WORD_W'(1) << bitpos_q;
  assign already = |(ram_rdata_i & bit_oh);
  assign cnt_new = already ? received_q : received_q + 1'b1;

  // chunks left from the base of the word under scan
  assign base       = REM_W'(addr_q) << BIT_W;
  assign rem        = REM_W'(expected_q) - base;
  assign last_word  = rem <= REM_W'(WORD_W);
  assign valid_mask = (rem >= REM_W'(WORD_W)) ? '1
                    : (WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1);
  assign miss       = ~ram_rdata_i & valid_mask;
  assign low_oh     = miss & (~miss + WORD_W'(1));

  always_comb begin
    low_pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (low_oh[b]) begin
        low_pos = low_pos | BIT_W'(b);
      end
    end
  end

  assign miss_idx = {addr_q, low_pos};

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    expected_d  = expected_q;
    received_d  = received_q;
    idle_d      = idle_q;
    addr_d      = addr_q;
    bitpos_d    = bitpos_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_wr_o    = '{we: 1'b0, addr: addr_q, data: '0};
    ram_raddr_o = ADDR_W'(in_req_i.chunk_number >> BIT_W);

    // drain the output register, then move a pending result into it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_d       = pend_res_q;
      pend_d      = 1'b0;
    end

    unique case (st_q)
      S_CLEAR: begin
        ram_wr_o = '{we: 1'b1, addr: addr_q, data: '0};
        if (addr_q == ADDR_W'(WORDS - 1)) begin
          st_d = S_READY;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_READY: begin
        if (in_req_i.action == ACT_TICK) begin
          ram_raddr_o = '0;
        end
        if (accept) begin
          unique case (in_req_i.action)
            ACT_START: begin
              idle_d     = '0;
              mode_d     = M_RECV;
              expected_d = (count_ext > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                         : CNT_W'(in_req_i.chunk_count);
              received_d = '0;
              addr_d     = '0;
              pend_d     = 1'b1;
              pend_res_d = '{reply_kind: REPLY_STATUS, report_code: STAT_STARTED,
                             missing_index: '0};
              st_d       = S_CLEAR;
            end
            ACT_STOP: begin
              idle_d     = '0;
              mode_d     = M_IDLE;
              pend_d     = 1'b1;
              pend_res_d = '{reply_kind: REPLY_STATUS, report_code: STAT_STOPPED,
                             missing_index: '0};
            end
            ACT_CHUNK: begin
              idle_d = '0;
              if (mode_q == M_RECV &&
                  32'(in_req_i.chunk_number) < 32'(expected_q)) begin
                addr_d   = ADDR_W'(in_req_i.chunk_number >> BIT_W);
                bitpos_d = in_req_i.chunk_number[BIT_W-1:0];
                st_d     = S_MARK;
              end
            end
            ACT_TICK: begin
              if (mode_q == M_RECV && idle_inc > timeout_i) begin
                idle_d = '0;
                addr_d = '0;
                st_d   = S_SCAN;
              end else begin
                idle_d = idle_inc;
              end
            end
            default: ;
          endcase
        end
      end
      S_MARK: begin
        if (!already) begin
          ram_wr_o   = '{we: 1'b1, addr: addr_q, data: ram_rdata_i | bit_oh};
          received_d = cnt_new;
        end
        if (cnt_new >= expected_q) begin
          mode_d     = M_DONE;
          pend_d     = 1'b1;
          pend_res_d = '{reply_kind: REPLY_STATUS, report_code: STAT_COMPLETE,
                         missing_index: '0};
        end
        st_d = S_READY;
      end
      S_SCAN: begin
        // data of word addr_q is here; fetch the next one meanwhile
        ram_raddr_o = addr_q + 1'b1;
        if (miss != '0) begin
          pend_d     = 1'b1;
          pend_res_d = '{reply_kind: REPLY_RETX, report_code: STAT_STOPPED,
                         missing_index: MISS_W'(miss_idx)};
          st_d       = S_READY;
        end else if (last_word) begin
          st_d = S_READY;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      default: st_d = S_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      mode_q      <= M_IDLE;
      expected_q  <= '0;
      received_q  <= '0;
      idle_q      <= '0;
      addr_q      <= '0;
      bitpos_q    <= '0;
      pend_q      <= 1'b0;
      pend_res_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      expected_q  <= expected_d;
      received_q  <= received_d;
      idle_q      <= idle_d;
      addr_q      <= addr_d;
      bitpos_q    <= bitpos_d;
      pend_q      <= pend_d;
      pend_res_q  <= pend_res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    received_q <= expected_q)
    else $error("received count above expected count");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_DONE |-> received_q == expected_q)
    else $error("complete with chunks missing");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_valid_q && !out_ready_i |=> pend_q && $stable(pend_res_q))
    else $error("pending result lost while output stalled");

  a_mark_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_MARK |-> $past(st_q) == S_READY && $past(in_valid_i))
    else $error("mark step without an accepted chunk");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import crt_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned PHASE_TIMEOUTS [NUM_PHASES] = '{1, 3, 65535, 2, 5, 1};
  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'(4 * REG_TIMEOUT);

  typedef enum logic [1:0] {
    XFER_IDLE      = 2'd0,
    XFER_RECEIVING = 2'd1,
    XFER_DONE      = 2'd2
  } xfer_mode_e;

  logic                  clk       = 1'b1;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  crt_req_t              in_req    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  crt_rsp_t              out_rsp;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // expected tracker state
  logic [IDLE_W-1:0]  timeout_cfg = TIMEOUT_RESET;
  xfer_mode_e         xfer_mode   = XFER_IDLE;
  bit                 chunk_seen [MAX_CHUNKS];
  logic [COUNT_W-1:0] chunks_due  = '0;
  logic [COUNT_W-1:0] chunks_got  = '0;
  logic [IDLE_W-1:0]  idle_ticks  = '0;

  crt_req_t    pending_reqs [$];
  crt_rsp_t    replies_due [$];
  int unsigned items_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  logic        req_fired    = 1'b0;
  logic        calm         = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned sink_stall   = 0;

  chunk_receipt_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Apply one request to the expected state; returns 1 when a reply is due.
  function automatic bit track_receipt(input crt_req_t req, output crt_rsp_t rsp);
    rsp = '0;
    if (req.action == ACT_TICK) begin
      if (idle_ticks != '1) idle_ticks++;
      if (xfer_mode == XFER_RECEIVING && idle_ticks > timeout_cfg) begin
        idle_ticks = '0;
        for (int k = 0; k < int'(chunks_due); k++) begin
          if (!chunk_seen[k]) begin
            rsp.reply_kind    = REPLY_RETX;
            rsp.missing_index = MISS_W'(k);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    end
    idle_ticks = '0;
    case (req.action)
      ACT_START: begin
        foreach (chunk_seen[k]) chunk_seen[k] = 1'b0;
        chunks_due = (req.chunk_count > MAX_CHUNKS) ? COUNT_W'(MAX_CHUNKS) : req.chunk_count;
        chunks_got = '0;
        xfer_mode  = XFER_RECEIVING;
        rsp.report_code = STAT_STARTED;
        return 1'b1;
      end
      ACT_STOP: begin
        xfer_mode = XFER_IDLE;
        rsp.report_code = STAT_STOPPED;
        return 1'b1;
      end
      default: begin
        if (xfer_mode != XFER_RECEIVING || req.chunk_number >= chunks_due) return 1'b0;
        if (!chunk_seen[req.chunk_number]) begin
          chunk_seen[req.chunk_number] = 1'b1;
          chunks_got++;
        end
        if (chunks_got >= chunks_due) begin
          xfer_mode = XFER_DONE;
          rsp.report_code = STAT_COMPLETE;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
      fail_count++;
    end
  endfunction

  function automatic void queue_req(input crt_act_e act, input int unsigned count,
                                    input int unsigned number);
    crt_req_t r;
    r.action       = act;
    r.chunk_count  = COUNT_W'(count);
    r.chunk_number = NUMBER_W'(number);
    pending_reqs.push_back(r);
    items_queued++;
  endfunction

  // One transfer: start, then mostly in-range chunks mixed with ticks and noise.
  function automatic void queue_transfer();
    int unsigned n, span, steps, r, burst;
    r = $urandom_range(0, 99);
    if (r < 8) n = 0;
    else if (r < 14) n = $urandom_range(4096, 8191);
    else n = $urandom_range(1, 24);
    span  = (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
    steps = (n == 0 || n > 64) ? $urandom_range(3, 20) : 3 * n + 4;
    burst = (timeout_cfg < 6) ? timeout_cfg + 2 : 6;
    queue_req(ACT_START, n, $urandom_range(0, 65535));
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        if (span == 0) queue_req(ACT_CHUNK, $urandom_range(0, 8191), 0);
        else if (span > 64 && r < 30)
          queue_req(ACT_CHUNK, $urandom_range(0, 8191), $urandom_range(0, 40));
        else queue_req(ACT_CHUNK, $urandom_range(0, 8191), $urandom_range(0, span - 1));
      end else if (r < 66) begin
        queue_req(ACT_CHUNK, $urandom_range(0, 8191), $urandom_range(0, 65535));
      end else if (r < 70) begin
        queue_req(ACT_CHUNK, $urandom_range(0, 8191), $urandom_range(span, span + 1));
      end else if (r < 97) begin
        repeat ($urandom_range(1, burst))
          queue_req(ACT_TICK, $urandom_range(0, 8191), $urandom_range(0, 65535));
      end else begin
        queue_req(ACT_STOP, $urandom_range(0, 8191), $urandom_range(0, 65535));
      end
    end
    if ($urandom_range(0, 3) == 0)
      queue_req(ACT_STOP, $urandom_range(0, 8191), $urandom_range(0, 65535));
  endfunction

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_valid || replies_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the timeout with junk in the upper bits, then read it back.
  task automatic write_timeout(input logic [IDLE_W-1:0] ticks);
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= CFG_DATA_W'({16'($urandom_range(0, 65535)), ticks});
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    timeout_cfg = ticks;
    check_field("timeout_ticks readback", ticks, readback[IDLE_W-1:0]);
  endtask

  // Hold each request until taken; gap between requests at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_req   <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall = pick_pause();
    end
  end

  always @(posedge clk) begin
    crt_rsp_t due;
    if (!rst_n) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none pending, actual %p", $time, out_rsp);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          check_field("reply_kind", due.reply_kind, out_rsp.reply_kind);
          check_field("report_code", due.report_code, out_rsp.report_code);
          check_field("missing_index", due.missing_index, out_rsp.missing_index);
        end
      end
      if (in_valid && in_ready) begin
        if (track_receipt(in_req, due)) replies_due.push_back(due);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset timeout: tick and chunk while idle, oversized count saturating
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_CHUNK, 0, 65535);
    queue_req(ACT_STOP, 8191, 65535);
    queue_req(ACT_START, 8191, 65535);
    queue_req(ACT_CHUNK, 0, 4095);
    queue_req(ACT_STOP, 0, 0);
    wait_quiet();

    write_timeout(1);
    // empty transfer: timeout finds nothing missing
    queue_req(ACT_START, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    // duplicates, out-of-range index, retransmit requests, completion
    queue_req(ACT_START, 3, 0);
    queue_req(ACT_CHUNK, 0, 1);
    queue_req(ACT_CHUNK, 0, 1);
    queue_req(ACT_CHUNK, 0, 3);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_CHUNK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_CHUNK, 0, 2);
    // chunk and timeout after completion, then restart
    queue_req(ACT_CHUNK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_TICK, 0, 0);
    queue_req(ACT_START, 1, 0);
    queue_req(ACT_CHUNK, 0, 0);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_timeout(IDLE_W'(PHASE_TIMEOUTS[p]));
      target = items_queued + ITEMS_PER_PHASE;
      while (items_queued < target) begin
        if ($urandom_range(0, 7) == 0)
          queue_req(crt_act_e'($urandom_range(0, 3)), $urandom_range(0, 8191),
                    $urandom_range(0, 65535));
        else
          queue_transfer();
      end
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### chunk_receipt_tracker.f
design/crt_pkg.sv
design/crt_ram.sv
design/crt_cfg.sv
design/crt_core.sv
design/chunk_receipt_tracker.sv
dv/tb.sv
